// ===== rtl/ttc_pkg.sv =====
// ttc_pkg: shared constants, register codes and helpers for the thermistor converter
// no dependencies; imported by thermistor_temperature_convert
package ttc_pkg;

  // configuration register codes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA,
    CFG_NOMINAL,
    CFG_TOP,
    CFG_BOTTOM,
    CFG_HEAT,
    CFG_SUPPLY
  } cfg_idx_t;

  // reset values of the registers
  localparam logic [15:0] BETA_RST    = 16'd3435;
  localparam logic [19:0] NOMINAL_RST = 20'd10000;
  localparam logic [19:0] TOP_RST     = 20'd10000;
  localparam logic [16:0] BOTTOM_RST  = 17'd200;
  localparam logic [19:0] HEAT_RST    = 20'd23000;
  localparam logic [15:0] SUPPLY_RST  = 16'd54067;

  // fixed-point constants
  localparam logic signed [30:0] LN2_Q30       = 31'sd744261118;
  localparam logic [54:0]        INV_T0_Q46    = 55'(((64'd1 << 46) * 20 + 2981) / 5963);
  localparam logic [15:0]        KELVIN_OFS_Q7 = 16'd34963;
  localparam logic signed [15:0] TEMP_LIMIT    = 16'sd32640;

  // widths of the datapath
  localparam int RQ_W     = 45;  // thermistor ohms, 8 fraction bits
  localparam int EXP_W    = 6;   // integer part of log2
  localparam int MAN_W    = 31;  // Q30 mantissa
  localparam int FRAC_W   = 16;  // fraction bits of log2
  localparam int LOG_W    = EXP_W + FRAC_W;

  // what travels beside the arithmetic
  typedef struct packed {
    logic       open;
    logic [1:0] ch;
  } side_t;

  // position of the leading one
  function automatic logic [EXP_W-1:0] msb_pos(input logic [RQ_W-1:0] x);
    logic [EXP_W-1:0] p;
    p = '0;
    for (int i = 0; i < RQ_W; i++) begin
      if (x[i]) p = EXP_W'(i);
    end
    return p;
  endfunction

endpackage

// ===== rtl/ttc_div.sv =====
// ttc_div: fully pipelined restoring divider, one quotient bit per stage
// standalone; used by thermistor_temperature_convert
module ttc_div #(
  parameter int NW = 8,  // dividend and quotient width
  parameter int DW = 8   // divisor width
) (
  input  logic          clk,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] acc_r [NW];  // dividend bits leave at the top, quotient bits enter below
  logic [DW-1:0] dvs_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] acc_in;
    logic [DW-1:0] dvs_in;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;
    logic          fits;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign acc_in = dividend;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign acc_in = acc_r[i-1];
      assign dvs_in = dvs_r[i-1];
    end

    assign shifted = {rem_in, acc_in[NW-1]};
    assign trial   = shifted - {1'b0, dvs_in};
    assign fits    = shifted >= {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      rem_r[i] <= fits ? trial[DW-1:0] : shifted[DW-1:0];
      acc_r[i] <= {acc_in[NW-2:0], fits};
      dvs_r[i] <= dvs_in;
    end
  end

  assign quotient = acc_r[NW-1];

endmodule

// ===== rtl/thermistor_temperature_convert.sv =====
// thermistor_temperature_convert: NTC divider voltage to Celsius via the beta equation
// depends on ttc_pkg and ttc_div
//
//   channel  ports                                      transfer
//   input    start, busy, in_sample_voltage, in_channel  start high and busy low at a clock edge
//   result   out_strobe, out_temperature, out_channel_out,
//            out_open_sensor                            one cycle with out_strobe high
//   config   cfg_we, cfg_index, cfg_wdata                cfg_we high at a clock edge
//
// one sample per clock; each result reaches the ports after passing the chain of
// bit-per-stage dividers (resistance, beta, kelvin) and the 16 squaring steps of
// the log2 unit
// busy is always low: the pipeline advances every cycle and never stalls; the
// receiver must take each result in the cycle it is shown, which the block does not check
// rst_n clears the valid bits and loads the register defaults; data stages need no reset
module thermistor_temperature_convert (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [15:0]                     in_sample_voltage,
  input  logic [1:0]                      in_channel,
  output logic                            out_strobe,
  output logic signed [15:0]              out_temperature,
  output logic [1:0]                      out_channel_out,
  output logic                            out_open_sensor,
  input  logic                            cfg_we,
  input  logic [ttc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ttc_pkg::*;

  // divider sizes
  localparam int DIV1_NW = RQ_W;  // (num << 8) / (S - V)
  localparam int IQ_NW   = 34;    // (S << 18) / Rtot
  localparam int HEAT_NW = 11;    // (P >> 17) / D
  localparam int DEN_NW  = 53;    // |ln| / beta
  localparam int K_NW    = 54;    // (2^53 + den/2) / den

  // stage numbers, counted in registers after the sample is taken
  localparam int ST_IN   = 1;
  localparam int ST_NUM  = ST_IN + 1;
  localparam int ST_RQ   = ST_NUM + DIV1_NW + 1;
  localparam int ST_LOG  = ST_RQ + 2 + FRAC_W;
  localparam int ST_LN   = ST_LOG + 1;
  localparam int ST_DEN  = ST_LN + DEN_NW + 1;
  localparam int ST_K    = ST_DEN + K_NW;
  localparam int ST_OUT  = ST_K + 1;
  localparam int ST_RT   = ST_RQ + 1;
  localparam int ST_IQ   = ST_RT + IQ_NW;
  localparam int ST_VP   = ST_IQ + 1;
  localparam int ST_VTH  = ST_VP + 1;
  localparam int ST_P    = ST_VTH + 1;
  localparam int ST_HEAT = ST_P + HEAT_NW;

  localparam int SIDE_DLY = ST_K - ST_IN;
  localparam int NEG_DLY  = DEN_NW;
  localparam int POS_DLY  = K_NW + 1;
  localparam int RQ_DLY   = ST_IQ - ST_RQ;
  localparam int HEAT_DLY = ST_K - ST_HEAT;

  // ---------------------------------------------------------------- configuration
  logic [15:0] beta_r;
  logic [19:0] nom_r;
  logic [19:0] top_r;
  logic [16:0] bot_r;
  logic [19:0] hdiv_r;
  logic [15:0] sup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= BETA_RST;
      nom_r  <= NOMINAL_RST;
      top_r  <= TOP_RST;
      bot_r  <= BOTTOM_RST;
      hdiv_r <= HEAT_RST;
      sup_r  <= SUPPLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BETA:    beta_r <= cfg_wdata[15:0];
        CFG_NOMINAL: nom_r  <= cfg_wdata;
        CFG_TOP:     top_r  <= cfg_wdata;
        CFG_BOTTOM:  bot_r  <= cfg_wdata[16:0];
        CFG_HEAT:    hdiv_r <= cfg_wdata;
        CFG_SUPPLY:  sup_r  <= cfg_wdata[15:0];
        default: ;  // unused codes are ignored
      endcase
    end
  end

  // a zero beta, nominal or heat divisor behaves as one
  logic [15:0] beta_eff;
  logic [19:0] nom_eff;
  logic [19:0] hdiv_eff;
  logic [20:0] rsum;

  assign beta_eff = (beta_r == '0) ? 16'd1 : beta_r;
  assign nom_eff  = (nom_r  == '0) ? 20'd1 : nom_r;
  assign hdiv_eff = (hdiv_r == '0) ? 20'd1 : hdiv_r;
  assign rsum     = 21'(top_r) + 21'(bot_r);

  // ---------------------------------------------------------------- handshake and valid line
  logic              accept;
  logic [ST_OUT-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ST_OUT-2:0], accept};
    end
  end

  // ---------------------------------------------------------------- stage 1: products
  logic [36:0] pa_r;   // V * (R1 + R2)
  logic [32:0] pb_r;   // S * R2
  logic [15:0] dvs_r;  // S - V
  side_t       side_r;

  always_ff @(posedge clk) begin
    pa_r        <= 37'(in_sample_voltage) * 37'(rsum);
    pb_r        <= 33'(sup_r) * 33'(bot_r);
    dvs_r       <= sup_r - in_sample_voltage;
    side_r.open <= in_sample_voltage >= sup_r;
    side_r.ch   <= in_channel;
  end

  // ---------------------------------------------------------------- stage 2: numerator
  logic signed [37:0] num;
  logic               num_pos;
  logic [RQ_W-1:0]    dnd1_r;
  logic [15:0]        dvs1_r;

  assign num     = $signed({1'b0, pa_r}) - $signed({5'b0, pb_r});
  assign num_pos = !num[37] && (num != '0);

  // a non-positive numerator yields zero here, which the floor below lifts to 1 ohm
  always_ff @(posedge clk) begin
    dnd1_r <= num_pos ? {num[36:0], 8'b0} : '0;
    dvs1_r <= dvs_r;
  end

  // ---------------------------------------------------------------- resistance divider
  logic [RQ_W-1:0] q1;
  logic [RQ_W-1:0] rq_r;

  ttc_div #(.NW(DIV1_NW), .DW(16)) u_div_rq (
    .clk      (clk),
    .dividend (dnd1_r),
    .divisor  (dvs1_r),
    .quotient (q1)
  );

  // floor at 1 ohm (256 in Q.8)
  always_ff @(posedge clk) begin
    rq_r <= (q1 < RQ_W'(256)) ? RQ_W'(256) : q1;
  end

  // ---------------------------------------------------------------- log2 lanes
  // lane 0 takes the thermistor, lane 1 the nominal resistance shifted to Q.8
  logic [RQ_W-1:0]   lane_in  [2];
  logic [RQ_W-1:0]   lx_r     [2];
  logic [EXP_W-1:0]  msb_r    [2];
  logic [MAN_W-1:0]  man_r    [2][FRAC_W+1];
  logic [EXP_W-1:0]  exp_r    [2][FRAC_W+1];
  logic [FRAC_W-1:0] frac_r   [2][FRAC_W+1];
  logic [LOG_W-1:0]  lg       [2];

  assign lane_in[0] = rq_r;
  assign lane_in[1] = RQ_W'({nom_eff, 8'b0});

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [RQ_W+MAN_W-2:0] wide;

    // leading-one search, then normalise to a Q30 mantissa
    always_ff @(posedge clk) begin
      lx_r[l]  <= lane_in[l];
      msb_r[l] <= msb_pos(lane_in[l]);
    end

    assign wide = {lx_r[l], 30'b0} >> msb_r[l];

    always_ff @(posedge clk) begin
      man_r[l][0]  <= wide[MAN_W-1:0];
      exp_r[l][0]  <= msb_r[l];
      frac_r[l][0] <= '0;
    end

    // one fraction bit per stage: square, halve when the square reaches 2
    for (genvar j = 1; j <= FRAC_W; j++) begin : g_step
      logic [2*MAN_W-1:0] sq;
      logic [MAN_W:0]     m2;
      logic [FRAC_W-1:0]  fr;

      assign sq = (2*MAN_W)'(man_r[l][j-1]) * (2*MAN_W)'(man_r[l][j-1]);
      assign m2 = sq[2*MAN_W-1:MAN_W-1];

      always_comb begin
        fr           = frac_r[l][j-1];
        fr[FRAC_W-j] = m2[MAN_W];
      end

      always_ff @(posedge clk) begin
        man_r[l][j]  <= m2[MAN_W] ? m2[MAN_W:1] : m2[MAN_W-1:0];
        exp_r[l][j]  <= exp_r[l][j-1];
        frac_r[l][j] <= fr;
      end
    end

    assign lg[l] = {exp_r[l][FRAC_W], frac_r[l][FRAC_W]};
  end

  // ---------------------------------------------------------------- natural log, Q46
  logic signed [LOG_W:0] lg_diff;
  logic signed [53:0]    ln_r;

  assign lg_diff = $signed({1'b0, lg[0]}) - $signed({1'b0, lg[1]});

  always_ff @(posedge clk) begin
    ln_r <= lg_diff * LN2_Q30;
  end

  // ---------------------------------------------------------------- ln / beta, on magnitudes
  logic [53:0]       ln_neg;
  logic [DEN_NW-1:0] ln_mag;
  logic [DEN_NW-1:0] den_q;
  logic              neg_dly_r [NEG_DLY];

  assign ln_neg = -ln_r;
  assign ln_mag = ln_r[53] ? ln_neg[DEN_NW-1:0] : ln_r[DEN_NW-1:0];

  ttc_div #(.NW(DEN_NW), .DW(16)) u_div_den (
    .clk      (clk),
    .dividend (ln_mag),
    .divisor  (beta_eff),
    .quotient (den_q)
  );

  always_ff @(posedge clk) begin
    neg_dly_r[0] <= ln_r[53];
    for (int i = 1; i < NEG_DLY; i++) neg_dly_r[i] <= neg_dly_r[i-1];
  end

  // ---------------------------------------------------------------- denominator, 1/T in Q46
  logic [54:0]       den_w;
  logic              den_pos;
  logic [K_NW-2:0]   ud_r;
  logic [K_NW-1:0]   nk_r;
  logic              pos_dly_r [POS_DLY];

  assign den_w   = neg_dly_r[NEG_DLY-1] ? (INV_T0_Q46 - 55'(den_q)) : (INV_T0_Q46 + 55'(den_q));
  assign den_pos = !den_w[54] && (den_w != '0);

  always_ff @(posedge clk) begin
    ud_r <= den_w[K_NW-2:0];
    nk_r <= (K_NW'(1) << 53) + K_NW'(den_w[K_NW-2:1]);  // rounding: add half the divisor
  end

  always_ff @(posedge clk) begin
    pos_dly_r[0] <= den_pos;
    for (int i = 1; i < POS_DLY; i++) pos_dly_r[i] <= pos_dly_r[i-1];
  end

  // ---------------------------------------------------------------- kelvin, Q7
  logic [K_NW-1:0] kel_q;

  ttc_div #(.NW(K_NW), .DW(K_NW-1)) u_div_k (
    .clk      (clk),
    .dividend (nk_r),
    .divisor  (ud_r),
    .quotient (kel_q)
  );

  // ---------------------------------------------------------------- self-heating branch
  logic [45:0]     rtot_r;
  logic [IQ_NW-1:0] sdv_r;
  logic [IQ_NW-1:0] iq_q;
  logic [25:0]     iq;
  logic [RQ_W-1:0] rq_dly_r [RQ_DLY];
  logic [RQ_W-1:0] rq_d;

  always_ff @(posedge clk) begin
    rtot_r <= 46'({rsum, 8'b0}) + 46'(rq_r);
    sdv_r  <= {sup_r, 18'b0};
  end

  always_ff @(posedge clk) begin
    rq_dly_r[0] <= rq_r;
    for (int i = 1; i < RQ_DLY; i++) rq_dly_r[i] <= rq_dly_r[i-1];
  end

  // current in amps Q24
  ttc_div #(.NW(IQ_NW), .DW(46)) u_div_iq (
    .clk      (clk),
    .dividend (sdv_r),
    .divisor  (rtot_r),
    .quotient (iq_q)
  );

  assign iq   = iq_q[25:0];
  assign rq_d = rq_dly_r[RQ_DLY-1];

  // thermistor voltage from two partial products
  logic [48:0] pl_r;
  logic [47:0] ph_r;
  logic [25:0] iq_vp_r;
  logic [70:0] vsum;
  logic [25:0] vth_r;
  logic [25:0] iq_vth_r;
  logic [51:0] pw;
  logic [HEAT_NW-1:0] hn_r;

  always_ff @(posedge clk) begin
    pl_r    <= 49'(iq) * 49'(rq_d[22:0]);
    ph_r    <= 48'(iq) * 48'(rq_d[RQ_W-1:23]);
    iq_vp_r <= iq;
  end

  assign vsum = 71'(pl_r) + (71'(ph_r) << 23);

  always_ff @(posedge clk) begin
    vth_r    <= vsum[33:8];
    iq_vth_r <= iq_vp_r;
  end

  // power in watts Q48; its top bits give the Q24 power pre-shifted by the 2^17 of the divisor
  assign pw = 52'(iq_vth_r) * 52'(vth_r);

  always_ff @(posedge clk) begin
    hn_r <= pw[51:41];
  end

  logic [HEAT_NW-1:0] heat_q;
  logic [HEAT_NW-1:0] heat_dly_r [HEAT_DLY];

  ttc_div #(.NW(HEAT_NW), .DW(20)) u_div_heat (
    .clk      (clk),
    .dividend (hn_r),
    .divisor  (hdiv_eff),
    .quotient (heat_q)
  );

  always_ff @(posedge clk) begin
    heat_dly_r[0] <= heat_q;
    for (int i = 1; i < HEAT_DLY; i++) heat_dly_r[i] <= heat_dly_r[i-1];
  end

  // ---------------------------------------------------------------- tag and open flag
  side_t side_dly_r [SIDE_DLY];

  always_ff @(posedge clk) begin
    side_dly_r[0] <= side_r;
    for (int i = 1; i < SIDE_DLY; i++) side_dly_r[i] <= side_dly_r[i-1];
  end

  // ---------------------------------------------------------------- Celsius, clamp, result
  logic signed [56:0] tw;
  logic signed [15:0] temp_nxt;
  side_t              side_k;
  logic signed [15:0] temp_r;
  logic [1:0]         chan_r;
  logic               open_r;

  assign side_k = side_dly_r[SIDE_DLY-1];
  assign tw     = $signed({3'b0, kel_q}) - $signed(57'(KELVIN_OFS_Q7))
                - $signed(57'(heat_dly_r[HEAT_DLY-1]));

  always_comb begin
    priority if (side_k.open) begin
      temp_nxt = -TEMP_LIMIT;
    end else if (!pos_dly_r[POS_DLY-1]) begin
      temp_nxt = TEMP_LIMIT;  // denominator not positive: far too hot
    end else if (tw > 57'(TEMP_LIMIT)) begin
      temp_nxt = TEMP_LIMIT;
    end else if (tw < -57'(TEMP_LIMIT)) begin
      temp_nxt = -TEMP_LIMIT;
    end else begin
      temp_nxt = tw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    temp_r <= temp_nxt;
    chan_r <= side_k.ch;
    open_r <= side_k.open;
  end

  assign out_strobe      = vld_r[ST_OUT-1];
  assign out_temperature = temp_r;
  assign out_channel_out = chan_r;
  assign out_open_sensor = open_r;

endmodule
